FILE: sv/md5_pkg.sv
// MD5 package: sine constants, rotate amounts, message word order, initial chaining values, channel structs.
// No dependencies.
package md5_pkg;
  localparam int WordWidth = 32;
  localparam int MsgDepth  = 16;
  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  function automatic logic [31:0] sine_const(input logic [5:0] i);
    logic [31:0] t [64];
    t = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
      32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
      32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
      32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
      32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
      32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    return t[i];
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] i);
    logic [4:0] r [16];
    r = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
          5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
    return r[{i[5:4], i[1:0]}];
  endfunction

  // message word index for step i
  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] s;
    s = i[3:0];
    unique case (i[5:4])
      2'd0: msg_index = s;
      2'd1: msg_index = 4'((s << 2) + s + 4'd1);
      2'd2: msg_index = 4'((s << 1) + s + 4'd5);
      default: msg_index = 4'((s << 3) - s);
    endcase
  endfunction

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_number;
    logic        final_word;
  } out_item_t;
endpackage

FILE: sv/md5_if.sv
// Valid/ready channel interface carrying one payload struct.
// No dependencies.
interface md5_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/md5_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module md5_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/md5_message_digest.sv
// MD5 hash top level: byte packing, padding, compression, digest output.
// Depends on md5_pkg, md5_if, md5_ram.
//
//  channel  | dir | payload
//  in_ch    | in  | data_byte, byte_present, end_of_message
//  out_ch   | out | digest_word, word_number, final_word
//
// A byte is taken while idle; the 64th byte of a block adds a compression,
// one step a cycle through the message word RAM read port. The end mark
// adds padding writes from the end word on, two length writes and one
// compression; past byte 55 another compression and 16 more padding
// writes come first. Then four output requests. Reset is synchronous and
// restores the chaining words. Input stalls in every state but idle.
module md5_message_digest (
  input logic clk,
  input logic rst,
  md5_if.sink   in_ch,
  md5_if.source out_ch
);
  import md5_pkg::*;
  localparam int Aw = $clog2(MsgDepth);

  typedef enum logic [2:0] {
    S_IDLE, S_COMP, S_PAD, S_LEN, S_OUT
  } state_t;

  state_t      state;
  logic [31:0] ca, cb, cc, cd, va, vb, vc, vd;
  logic [63:0] byte_count;
  logic [31:0] wbuf;     // partial word being packed
  logic [6:0]  step;     // 0..64 compression; pad word counter
  logic        pad_more; // second compression still needed
  logic        pad_all;  // all-zero block: write every word
  logic        fin;      // compression ends the message
  logic [1:0]  onum;

  logic            we;
  logic [Aw-1:0]   waddr, raddr;
  logic [31:0]     wdata, rdata;

  md5_ram #(.Width(WordWidth), .Depth(MsgDepth)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  in_item_t it;
  assign it = in_ch.payload;
  assign in_ch.ready = (state == S_IDLE);
  wire acc = in_ch.valid && in_ch.ready;

  logic [5:0] pos;
  logic [31:0] packed_w;
  assign pos = byte_count[5:0];
  always_comb begin
    packed_w = wbuf;
    packed_w[pos[1:0]*8 +: 8] = it.data_byte;
  end

  // pad word for word index k after end position p
  logic [5:0] ep;      // end position after optional byte
  logic [5:0] pp;
  logic [31:0] pad_w;
  logic [3:0]  pk;
  assign ep = it.byte_present ? 6'(pos + 6'd1) : pos;
  assign pk = step[3:0];
  always_comb begin
    pad_w = 32'd0;
    for (int j = 0; j < 4; j++) begin
      if ({pk, 2'(j)} < pp) pad_w[j*8 +: 8] = wbuf[j*8 +: 8];
      else if ({pk, 2'(j)} == pp) pad_w[j*8 +: 8] = 8'h80;
    end
  end

  // compression step datapath; rdata holds word for step-1
  logic [5:0]  cs;
  logic [31:0] f, sum, rot;
  logic [4:0]  ra;
  assign cs = 6'(step - 7'd1);
  always_comb begin
    unique case (cs[5:4])
      2'd0: f = (vb & vc) | (~vb & vd);
      2'd1: f = (vb & vd) | (vc & ~vd);
      2'd2: f = vb ^ vc ^ vd;
      default: f = vc ^ (vb | ~vd);
    endcase
    sum = f + va + sine_const(cs) + rdata;
    ra  = rot_amount(cs);
    rot = (sum << ra) | (sum >> (6'd32 - {1'b0, ra}));
  end

  logic [63:0] bits;
  assign bits = {byte_count[60:0], 3'b000};

  always_comb begin
    we = 1'b0; waddr = '0; wdata = packed_w;
    raddr = msg_index(step[5:0]);
    if (acc && it.byte_present && pos[1:0] == 2'd3) begin
      we = 1'b1; waddr = pos[5:2];
    end else if (state == S_PAD) begin
      // words below the end word keep their data
      we = pad_all || (pk >= pp[5:2]); waddr = pk; wdata = pad_w;
    end else if (state == S_LEN) begin
      we = 1'b1; waddr = Aw'(step[0] ? 15 : 14);
      wdata = step[0] ? bits[63:32] : bits[31:0];
    end
  end

  out_item_t oi;
  always_comb begin
    oi.word_number = onum;
    oi.final_word  = (onum == 2'd3);
    unique case (onum)
      2'd0: oi.digest_word = ca;
      2'd1: oi.digest_word = cb;
      2'd2: oi.digest_word = cc;
      default: oi.digest_word = cd;
    endcase
  end
  assign out_ch.payload = oi;
  assign out_ch.valid = (state == S_OUT);

  function automatic logic in_ch_pending_pad(input logic [5:0] p, input logic m);
    return m && p != 6'd0;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ca <= InitA; cb <= InitB; cc <= InitC; cd <= InitD;
      byte_count <= '0; step <= '0; onum <= '0;
      pad_more <= 1'b0; pad_all <= 1'b0; fin <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (acc) begin
          step <= '0;
          va <= ca; vb <= cb; vc <= cc; vd <= cd;
          if (it.byte_present) begin
            wbuf <= packed_w;
            byte_count <= byte_count + 64'd1;
          end
          if (it.byte_present && pos == 6'd63) begin
            // byte completing block: compress it first; at message end, then pad a fresh block
            state <= S_COMP;
            fin <= 1'b0;
            pad_more <= 1'b0;
            pp <= it.end_of_message ? 6'd0 : 6'd63;
          end else if (it.end_of_message) begin
            state <= S_PAD;
            fin <= 1'b0;
            pp <= ep;
            pad_more <= (ep >= 6'd56);
            pad_all <= 1'b0;
          end
        end
        S_PAD: begin
          if (pk == 4'd15) begin
            step <= '0;
            pad_all <= 1'b0;
            va <= ca; vb <= cb; vc <= cc; vd <= cd;
            if (pad_more) begin state <= S_COMP; fin <= 1'b0; end
            else state <= S_LEN;
          end else step <= step + 7'd1;
        end
        S_LEN: begin
          if (step[0]) begin
            step <= '0; state <= S_COMP; fin <= 1'b1;
          end else step <= step + 7'd1;
        end
        S_COMP: begin
          if (step != 7'd0) begin
            va <= vd; vd <= vc; vc <= vb; vb <= vb + rot;
          end
          if (step == 7'd64) begin
            ca <= ca + vd; cb <= cb + vb + rot; cc <= cc + vb; cd <= cd + vc;
            step <= '0;
            if (fin) begin state <= S_OUT; onum <= '0; end
            else if (in_ch_pending_pad(pp, pad_more)) begin
              // first of two end blocks done: next block is all zero before length
              pad_more <= 1'b0;
              pad_all <= 1'b1;
              pp <= 6'd63;
              wbuf <= '0;
              state <= S_PAD;
            end else if (pp == 6'd0) begin
              wbuf <= '0;
              state <= S_PAD;
            end else state <= S_IDLE;
          end else step <= step + 7'd1;
        end
        S_OUT: if (out_ch.ready) begin
          onum <= onum + 2'd1;
          if (onum == 2'd3) begin
            state <= S_IDLE;
            ca <= InitA; cb <= InitB; cc <= InitC; cd <= InitD;
            byte_count <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
